FILE: sv/lap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lap_pkg;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_COLS = 1'b0,
        CFG_ROWS = 1'b1
    } t_cfg_idx;

    localparam int CFG_BITS      = 13;
    localparam int COLS_REG_BITS = 11;
    localparam int ROWS_REG_BITS = 13;
    localparam int ROW_OUT_BITS  = 12;
    localparam int COL_OUT_BITS  = 10;
    localparam int QUEUE_DEPTH   = 4;

    // classification of one sample, front to back
    typedef struct packed {
        logic                    emit;
        logic                    last;
        logic                    col_zero;
        logic [ROW_OUT_BITS-1:0] row;
        logic [COL_OUT_BITS-1:0] col;
    } t_tag;

endpackage

`default_nettype wire

FILE: sv/lap_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lap_in_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          grid_start;

    modport source (output valid, sample, grid_start, input ready);
    modport sink (input valid, sample, grid_start, output ready);
endinterface

`default_nettype wire

FILE: sv/lap_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lap_out_if #(
    parameter int SAMPLE_BITS = 32
) ();
    logic                                  valid;
    logic                                  ready;
    logic signed [SAMPLE_BITS+3:0]         stencil_value;
    logic [lap_pkg::ROW_OUT_BITS-1:0]      out_row;
    logic [lap_pkg::COL_OUT_BITS-1:0]      out_col;
    logic                                  grid_last;

    modport source (output valid, stencil_value, out_row, out_col, grid_last, input ready);
    modport sink (input valid, stencil_value, out_row, out_col, grid_last, output ready);
endinterface

`default_nettype wire

FILE: sv/laplacian_five_point_stencil.sv
// Channel   Dir  Fields                                          Transfer when
// i_in      in   sample, grid_start                              valid && ready
// o_out     out  stencil_value, out_row, out_col, grid_last      valid && ready
// i_cfg     in   i_cfg_we, i_cfg_idx, i_cfg_data                 i_cfg_we
//
// One sample per cycle unless o_out stalls; results pass the queue, s2 and output registers.
// Rate is set by the line store: one read port and one write port, each used once per sample.
// Synchronous active-low reset clears counters, queue and valids; line store is not cleared.
// Input and output stall independently through a 4-entry queue and the output register.
`timescale 1ns / 1ps
`default_nettype none

module laplacian_five_point_stencil #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lap_in_if.sink                              i_in,
    lap_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire lap_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [lap_pkg::CFG_BITS-1:0]   i_cfg_data
);
    import lap_pkg::*;

    localparam int AW = $clog2(MAX_COLS + 2);
    localparam int QW = SAMPLE_BITS + AW + $bits(t_tag);

    logic                          push, pop, q_full, q_empty;
    logic signed [SAMPLE_BITS-1:0] f_sample, b_sample;
    logic [AW-1:0]                 f_addr, b_addr;
    t_tag                          f_tag, b_tag;
    logic [QW-1:0]                 q_in, q_out;

    lap_front #(
        .MAX_COLS   (MAX_COLS),
        .MAX_ROWS   (MAX_ROWS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_q_full  (q_full),
        .o_push    (push),
        .o_sample  (f_sample),
        .o_addr    (f_addr),
        .o_tag     (f_tag)
    );

    assign q_in = {f_sample, f_addr, f_tag};

    lap_fifo #(
        .W(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (q_in),
        .i_pop  (pop),
        .o_data (q_out),
        .o_full (q_full),
        .o_empty(q_empty)
    );

    assign {b_sample, b_addr, b_tag} = q_out;

    lap_back #(
        .MAX_COLS   (MAX_COLS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_sample(b_sample),
        .i_addr  (b_addr),
        .i_tag   (b_tag),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

FILE: sv/lap_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lap_front #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 4096,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    lap_in_if.sink                              i_in,
    input  wire logic                           i_cfg_we,
    input  wire lap_pkg::t_cfg_idx              i_cfg_idx,
    input  wire logic [lap_pkg::CFG_BITS-1:0]   i_cfg_data,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output logic signed [SAMPLE_BITS-1:0]       o_sample,
    output logic [$clog2(MAX_COLS+2)-1:0]       o_addr,
    output lap_pkg::t_tag                       o_tag
);
    import lap_pkg::*;

    localparam int CW = $clog2(MAX_COLS + 3);
    localparam int RW = $clog2(MAX_ROWS + 3);
    localparam int AW = $clog2(MAX_COLS + 2);

    logic [CW-1:0] r_width, n_width;
    logic [RW-1:0] r_height, n_height;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [COLS_REG_BITS-1:0] cols_v;
    logic [ROWS_REG_BITS-1:0] rows_v;
    logic acc;

    assign i_in.ready = !i_q_full;
    assign acc        = i_in.valid && i_in.ready;

    assign cols_v = i_cfg_data[COLS_REG_BITS-1:0];
    assign rows_v = i_cfg_data[ROWS_REG_BITS-1:0];

    // padded sizes, register clamped to 1..max
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLS: begin
                    if (cols_v == '0) begin
                        n_width = CW'(3);
                    end else if (32'(cols_v) > MAX_COLS) begin
                        n_width = CW'(MAX_COLS + 2);
                    end else begin
                        n_width = CW'(32'(cols_v) + 2);
                    end
                end
                CFG_ROWS: begin
                    if (rows_v == '0) begin
                        n_height = RW'(3);
                    end else if (32'(rows_v) > MAX_ROWS) begin
                        n_height = RW'(MAX_ROWS + 2);
                    end else begin
                        n_height = RW'(32'(rows_v) + 2);
                    end
                end
                default: ;
            endcase
        end
    end

    assign cur_row = i_in.grid_start ? '0 : r_row;
    assign cur_col = i_in.grid_start ? '0 : r_col;

    always_comb begin
        n_row = r_row;
        n_col = r_col;
        if (acc) begin
            if (cur_col >= r_width - CW'(1)) begin
                n_col = '0;
                n_row = (cur_row >= r_height - RW'(1)) ? '0 : cur_row + RW'(1);
            end else begin
                n_col = cur_col + CW'(1);
                n_row = cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(MAX_COLS + 2);
            r_height <= RW'(MAX_ROWS + 2);
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    assign o_push       = acc;
    assign o_sample     = i_in.sample;
    assign o_addr       = cur_col[AW-1:0];
    assign o_tag.emit   = (cur_row >= RW'(2)) && (cur_col >= CW'(2))
                          && (cur_row < r_height) && (cur_col < r_width);
    assign o_tag.last   = (cur_row == r_height - RW'(1)) && (cur_col == r_width - CW'(1));
    assign o_tag.col_zero = (cur_col == '0);
    assign o_tag.row    = ROW_OUT_BITS'(cur_row - RW'(2));
    assign o_tag.col    = COL_OUT_BITS'(cur_col - CW'(2));

    // last interior point always lies inside the interior
    a_last_is_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_tag.last) |-> o_tag.emit)
        else $error("last flag on a point without result");

endmodule

`default_nettype wire

FILE: sv/lap_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module lap_fifo #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_data,
    output logic              o_full,
    output logic              o_empty
);
    import lap_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    logic [W-1:0]  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [PW:0]   r_count, n_count;

    assign o_full  = (r_count == (PW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (PW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (PW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (PW+1)'(DEPTH))
        else $error("queue count overflow");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: sv/lap_back.sv
`timescale 1ns / 1ps
`default_nettype none

module lap_back #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_empty,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  wire logic [$clog2(MAX_COLS+2)-1:0]     i_addr,
    input  wire lap_pkg::t_tag                     i_tag,
    output logic                                   o_pop,
    lap_out_if.source                              o_out
);
    import lap_pkg::*;

    localparam int AW    = $clog2(MAX_COLS + 2);
    localparam int DEPTH = MAX_COLS + 2;
    localparam int SB    = SAMPLE_BITS;
    localparam int OB    = SAMPLE_BITS + 4;

    // line store: {upper row, middle row} per padded column
    logic [2*SB-1:0] r_line [DEPTH];
    logic [2*SB-1:0] r_rdata;
    logic [2*SB-1:0] r_fwd_data;
    logic            r_fwd_hit;

    logic                 r_s2_valid;
    logic signed [SB-1:0] r_s2_sample;
    logic [AW-1:0]        r_s2_addr;
    t_tag                 r_s2_tag;

    logic signed [SB-1:0] r_win0, r_win1, r_win2, r_prev;

    logic                    r_out_valid;
    logic signed [OB-1:0]    r_out_value;
    logic [ROW_OUT_BITS-1:0] r_out_row;
    logic [COL_OUT_BITS-1:0] r_out_col;
    logic                    r_out_last;

    logic                 s2_fire;
    logic [2*SB-1:0]      row_q;
    logic [2*SB-1:0]      wr_data;
    logic signed [SB-1:0] up_c, mid_c, down;
    logic signed [OB-1:0] result;

    assign s2_fire = r_s2_valid && (!r_s2_tag.emit || !r_out_valid || o_out.ready);
    assign o_pop   = !i_empty && (!r_s2_valid || s2_fire);

    assign row_q   = r_fwd_hit ? r_fwd_data : r_rdata;
    assign up_c    = row_q[2*SB-1:SB];
    assign mid_c   = row_q[SB-1:0];
    assign down    = r_s2_tag.col_zero ? '0 : r_prev;
    assign wr_data = {mid_c, r_s2_sample};

    assign result = (OB'(r_win1) <<< 2)
                  - (OB'(r_win0) + OB'(down) + OB'(r_win2) + OB'(mid_c));

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_line[r_s2_addr] <= wr_data;
        end
        if (o_pop) begin
            r_rdata <= r_line[i_addr];
        end
    end

    // read-during-write bypass for the entry being written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (o_pop) begin
            r_fwd_hit <= s2_fire && (i_addr == r_s2_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_fwd_data  <= wr_data;
            r_s2_sample <= i_sample;
            r_s2_addr   <= i_addr;
            r_s2_tag    <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (o_pop) begin
            r_s2_valid <= 1'b1;
        end else if (s2_fire) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= '0;
            r_win1 <= '0;
            r_win2 <= '0;
        end else if (s2_fire) begin
            r_win2 <= r_win1;
            r_win1 <= mid_c;
            r_win0 <= up_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_prev <= r_s2_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_fire && r_s2_tag.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_fire && r_s2_tag.emit) begin
            r_out_value <= result;
            r_out_row   <= r_s2_tag.row;
            r_out_col   <= r_s2_tag.col;
            r_out_last  <= r_s2_tag.last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.stencil_value = r_out_value;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.grid_last     = r_out_last;

    // a result blocked at the output holds the queue head in place
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_tag.emit && r_out_valid && !o_out.ready) |-> !o_pop)
        else $error("pop while result stage stalled");

endmodule

`default_nettype wire
